@@ rtl/core/dxtd_pkg.sv @@
// dxtd_pkg: shared types, constants and divide helpers for the block decoder
// used by the channel interfaces, the palette stage and the top level
package dxtd_pkg;

   localparam int unsigned TexelCount = 16;
   localparam int unsigned CntWidth   = $clog2(TexelCount);
   localparam int unsigned WordWidth  = 64;
   localparam int unsigned ChanWidth  = 8;

   // reciprocal multipliers, exact floor over the numerator ranges used here
   localparam logic [9:0]  Div3Mul = 10'd683;   // / 2^11, x <= 765
   localparam logic [10:0] Div5Mul = 11'd1639;  // / 2^13, x <= 1275
   localparam logic [11:0] Div7Mul = 12'd2341;  // / 2^14, x <= 1785

   typedef enum logic [1:0] {
      FormatDxt1 = 2'd0,
      FormatDxt3 = 2'd1,
      FormatDxt5 = 2'd2
   } format_type;

   typedef logic [ChanWidth-1:0] chan_type;

   // one decoded block, ready for texel selection
   typedef struct packed {
      chan_type [3:0] red;
      chan_type [3:0] green;
      chan_type [3:0] blue;
      logic           four_colour;
      chan_type [7:0] alpha_tab;
      logic [2*TexelCount-1:0] colour_idx;
      logic [WordWidth-1:0]    alpha_word;
      logic [1:0]              format;
   } dec_block_type;

   function automatic chan_type div3(input logic [9:0] x);
      logic [19:0] p;
      p = 20'(x) * 20'(Div3Mul);
      return p[18:11];
   endfunction

   function automatic chan_type div5(input logic [10:0] x);
      logic [21:0] p;
      p = 22'(x) * 22'(Div5Mul);
      return p[20:13];
   endfunction

   function automatic chan_type div7(input logic [10:0] x);
      logic [22:0] p;
      p = 23'(x) * 23'(Div7Mul);
      return p[21:14];
   endfunction

endpackage

@@ rtl/core/dxtd_if.sv @@
// dxtd channel interfaces: block request, texel response and register write
// depends on dxtd_pkg for widths
interface dxtd_req_if import dxtd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [WordWidth-1:0] color_word;
   logic [WordWidth-1:0] alpha_word;
   modport source (output valid, color_word, alpha_word, input ready);
   modport sink   (input valid, color_word, alpha_word, output ready);
endinterface

interface dxtd_rsp_if import dxtd_pkg::*; ();
   logic     valid;
   logic     ready;
   chan_type red;
   chan_type green;
   chan_type blue;
   chan_type alpha;
   logic [1:0] texel_col;
   logic [1:0] texel_row;
   logic       last;
   modport source (output valid, red, green, blue, alpha, texel_col, texel_row, last,
                   input ready);
   modport sink   (input valid, red, green, blue, alpha, texel_col, texel_row, last,
                   output ready);
endinterface

interface dxtd_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

@@ rtl/core/dxt_block_decoder.sv @@
// dxt_block_decoder: s3tc (dxt1/dxt3/dxt5) 4x4 block decompressor, top level
// depends on dxtd_pkg, the dxtd channel interfaces and dxtd_palette
//
// usage
//  - req: one compressed block per word (colour half and alpha half, 64 bits each)
//  - rsp: one texel per word, raster order, col/row tags, last on the sixteenth
//  - csr: writes format_mode (0 dxt1, 1 dxt3, 2 dxt5, 3 acts as dxt1); always ready,
//    write it only while no block is in flight
//  - blocks: each block leaves as sixteen words on the one-texel-per-word rsp channel;
//    the next block is taken while the current one still drains, so blocks run
//    back to back with no gap on rsp
//  - pipeline: input register, decoded-block register (palette and alpha table
//    built on the way in), then a texel counter selecting into the rsp register
//  - stall: when rsp.ready is low the rsp register holds, the counter stops, and
//    req.ready drops once the input register is also full
//  - reset: synchronous, clears all valid flags, the counter and format_mode (dxt1)
module dxt_block_decoder import dxtd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   dxtd_req_if.sink        req,
   dxtd_rsp_if.source      rsp,
   dxtd_csr_if.sink        csr
);

   // configuration
   logic [1:0] format_ff;

   // input register
   logic                 in_valid_ff;
   logic [WordWidth-1:0] in_color_ff;
   logic [WordWidth-1:0] in_alpha_ff;

   // decoded block register and texel counter
   logic          blk_valid_ff;
   dec_block_type blk_ff;
   dec_block_type blk_in;
   logic [CntWidth-1:0] cnt_ff;

   // response register
   logic     rsp_valid_ff;
   chan_type red_ff, green_ff, blue_ff, alpha_ff;
   logic [1:0] col_ff, row_ff;
   logic       last_ff;

   logic out_free, emit, blk_done, blk_load;
   logic [1:0] ci;
   logic [2:0] ai;
   logic [3:0] nib;
   chan_type   alpha_sel;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign emit     = blk_valid_ff && out_free;
   assign blk_done = emit && (cnt_ff == CntWidth'(TexelCount - 1));
   assign blk_load = in_valid_ff && (!blk_valid_ff || blk_done);
   assign req.ready = !in_valid_ff || blk_load;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= FormatDxt1;
      end else if (csr.valid) begin
         format_ff <= csr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
      if (req.valid && req.ready) begin
         in_color_ff <= req.color_word;
         in_alpha_ff <= req.alpha_word;
      end
   end

   dxtd_palette u_palette (
      .color_word (in_color_ff),
      .alpha_word (in_alpha_ff),
      .format     (format_ff),
      .block      (blk_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         if (blk_load) begin
            blk_valid_ff <= 1'b1;
         end else if (blk_done) begin
            blk_valid_ff <= 1'b0;
         end
         if (emit) begin
            cnt_ff <= cnt_ff + CntWidth'(1);  // wraps to zero after the last texel
         end
      end
      if (blk_load) begin
         blk_ff <= blk_in;
      end
   end

   // texel selection
   assign ci  = blk_ff.colour_idx[2*cnt_ff +: 2];
   assign ai  = blk_ff.alpha_word[16 + 3*cnt_ff +: 3];
   assign nib = blk_ff.alpha_word[4*cnt_ff +: 4];

   always_comb begin
      case (format_type'(blk_ff.format))
         FormatDxt3: alpha_sel = {nib, nib};
         FormatDxt5: alpha_sel = blk_ff.alpha_tab[ai];
         default: begin
            // transparent black only at index 3 in three-colour mode
            alpha_sel = (ci == 2'd3 && !blk_ff.four_colour) ? '0 : '1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= blk_valid_ff;
      end
      if (emit) begin
         red_ff   <= blk_ff.red[ci];
         green_ff <= blk_ff.green[ci];
         blue_ff  <= blk_ff.blue[ci];
         alpha_ff <= alpha_sel;
         col_ff   <= cnt_ff[1:0];
         row_ff   <= cnt_ff[3:2];
         last_ff  <= (cnt_ff == CntWidth'(TexelCount - 1));
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.red       = red_ff;
   assign rsp.green     = green_ff;
   assign rsp.blue      = blue_ff;
   assign rsp.alpha     = alpha_ff;
   assign rsp.texel_col = col_ff;
   assign rsp.texel_row = row_ff;
   assign rsp.last      = last_ff;

   // counter only runs while a block is held
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      !blk_valid_ff |-> cnt_ff == '0)
      else $error("texel counter moved without a block");

   // last flag sits on the bottom-right texel only
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (last_ff == (col_ff == 2'd3 && row_ff == 2'd3)))
      else $error("last flag on wrong texel");

   // finishing a block puts a last texel on rsp
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      blk_done |=> rsp_valid_ff && last_ff)
      else $error("block finished without last texel");

   // a new block is only loaded when the decoded register is free or draining
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      blk_load && blk_valid_ff |-> blk_done)
      else $error("decoded block overwritten mid-drain");

endmodule

@@ rtl/core/dxtd_palette.sv @@
// dxtd_palette: builds the colour palette and alpha table of one block
// depends on dxtd_pkg (types and reciprocal divide helpers)
module dxtd_palette import dxtd_pkg::*; (
   input  logic [WordWidth-1:0] color_word,
   input  logic [WordWidth-1:0] alpha_word,
   input  logic [1:0]           format,
   output dec_block_type        block
);

   logic [15:0] c0, c1;
   chan_type    e0 [3];
   chan_type    e1 [3];
   chan_type    p2 [3];
   chan_type    p3 [3];
   chan_type    a0, a1;
   logic        four;
   logic        alpha_hi;

   assign c0 = color_word[15:0];
   assign c1 = color_word[31:16];
   assign four = (c0 > c1);
   assign a0 = alpha_word[7:0];
   assign a1 = alpha_word[15:8];
   assign alpha_hi = (a0 > a1);

   // endpoints widened with zero low bits: red, green, blue
   assign e0[0] = {c0[15:11], 3'b000};
   assign e0[1] = {c0[10:5],  2'b00};
   assign e0[2] = {c0[4:0],   3'b000};
   assign e1[0] = {c1[15:11], 3'b000};
   assign e1[1] = {c1[10:5],  2'b00};
   assign e1[2] = {c1[4:0],   3'b000};

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (four) begin
            p2[k] = div3(10'({e0[k], 1'b0}) + 10'(e1[k]));
            p3[k] = div3(10'(e0[k]) + 10'({e1[k], 1'b0}));
         end else begin
            p2[k] = 8'((9'(e0[k]) + 9'(e1[k])) >> 1);
            p3[k] = '0;
         end
      end
   end

   always_comb begin
      block = '0;
      block.red   = {p3[0], p2[0], e1[0], e0[0]};
      block.green = {p3[1], p2[1], e1[1], e0[1]};
      block.blue  = {p3[2], p2[2], e1[2], e0[2]};
      block.four_colour = four;
      block.alpha_tab[0] = a0;
      block.alpha_tab[1] = a1;
      for (int k = 2; k < 8; k++) begin
         if (alpha_hi) begin
            block.alpha_tab[k] = div7(11'(8 - k) * 11'(a0) + 11'(k - 1) * 11'(a1));
         end else if (k < 6) begin
            block.alpha_tab[k] = div5(11'(6 - k) * 11'(a0) + 11'(k - 1) * 11'(a1));
         end else if (k == 6) begin
            block.alpha_tab[k] = '0;
         end else begin
            block.alpha_tab[k] = '1;
         end
      end
      block.colour_idx = color_word[63:32];
      block.alpha_word = alpha_word;
      block.format     = format;
   end

endmodule

@@ sim/tb_top.sv @@
// tb_top: self-checking bench for the dxt1/dxt3/dxt5 block decoder
// drives blocks from a directed table and then random phases, each texel word checked
// against the table or an in-bench decoder; depends on dxtd_pkg, dxtd_if and the rtl
module tb_top;
   import dxtd_pkg::*;

   localparam int ClkPeriod     = 20;
   localparam int ResetCycles   = 7;
   localparam int DrainCycles   = 6;      // quiet wait once the texel queue has emptied
   localparam int LongHold      = 300;    // receiver hold-off that backs the block up
   localparam int TimeoutCycles = 400000;
   localparam int ReportLimit   = 40;
   localparam int NumDirected   = 19;
   localparam int NumPhases     = 7;
   localparam int PhaseBlocks   = 42;

   // format code 3 is not in the enum, the block decodes it as dxt1
   localparam logic [1:0] FormatSpare = 2'd3;

   // expected texel word, same order as the rsp payload
   typedef struct packed {
      chan_type   red;
      chan_type   green;
      chan_type   blue;
      chan_type   alpha;
      logic [1:0] col;
      logic [1:0] row;
      logic       last;
   } texel_type;

   // one directed block: a uniform colour is given where it is plain to see,
   // otherwise the in-bench decoder supplies the texels
   typedef struct packed {
      logic [1:0]  fmt;
      logic [63:0] color_word;
      logic [63:0] alpha_word;
      logic        typed;
      chan_type    red;
      chan_type    green;
      chan_type    blue;
      chan_type    alpha;
   } dir_row_type;

   // colour indices 0,1,2,3 across each row of the block
   localparam logic [31:0] IdxRamp   = 32'hE4E4_E4E4;
   // dxt5 alpha indices 0..7 twice over
   localparam logic [47:0] AlphaRamp = 48'hFAC688_FAC688;

   dir_row_type dir_rows [NumDirected] = '{
      // dxt1 straight after reset, no register write yet
      '{FormatDxt1, 64'h0, 64'h0, 1'b1, 8'd0, 8'd0, 8'd0, 8'd255},
      '{FormatDxt1, 64'h0000_0000_0000_FFFF, '1, 1'b1, 8'd248, 8'd252, 8'd248, 8'd255},
      '{FormatDxt1, '1, 64'h0, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0},
      '{FormatDxt1, 64'h5555_5555_0000_FFFF, 64'h0, 1'b1, 8'd0, 8'd0, 8'd0, 8'd255},
      '{FormatDxt1, {IdxRamp, 32'h001F_F800}, 64'h0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{FormatDxt1, {IdxRamp, 32'hF800_001F}, 64'h0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
      '{FormatDxt1, {32'h1B1B_1B1B, 32'h7BEF_7BF0}, '1, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
      // dxt3 explicit alpha
      '{FormatDxt3, 64'h0000_0000_0000_F800, '1, 1'b1, 8'd248, 8'd0, 8'd0, 8'd255},
      '{FormatDxt3, 64'h0000_0000_0000_F800, 64'h0, 1'b1, 8'd248, 8'd0, 8'd0, 8'd0},
      '{FormatDxt3, '1, '1, 1'b1, 8'd0, 8'd0, 8'd0, 8'd255},
      '{FormatDxt3, {IdxRamp, 32'hF800_07E0}, 64'hFEDC_BA98_7654_3210, 1'b0,
        8'd0, 8'd0, 8'd0, 8'd0},
      // dxt5 interpolated alpha
      '{FormatDxt5, 64'h0000_0000_0000_07E0, 64'h00FF, 1'b1, 8'd0, 8'd252, 8'd0, 8'd255},
      '{FormatDxt5, 64'h0000_0000_0000_07E0, 64'hFFFF_FFFF_FFFF_0000, 1'b1,
        8'd0, 8'd252, 8'd0, 8'd255},
      '{FormatDxt5, {IdxRamp, 32'hF800_001F}, {AlphaRamp, 16'h10F0}, 1'b0,
        8'd0, 8'd0, 8'd0, 8'd0},
      '{FormatDxt5, {IdxRamp, 32'h001F_F800}, {AlphaRamp, 16'hF010}, 1'b0,
        8'd0, 8'd0, 8'd0, 8'd0},
      '{FormatDxt5, {IdxRamp, 32'hFFFF_FFFF}, {AlphaRamp, 16'hFFFF}, 1'b0,
        8'd0, 8'd0, 8'd0, 8'd0},
      '{FormatDxt5, {IdxRamp, 32'h0000_FFFF}, {AlphaRamp, 16'h00FF}, 1'b0,
        8'd0, 8'd0, 8'd0, 8'd0},
      // spare code behaves as dxt1, alpha half ignored
      '{FormatSpare, '1, '1, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0},
      '{FormatSpare, {IdxRamp, 32'h001F_F800}, 64'h0123_4567_89AB_CDEF, 1'b0,
        8'd0, 8'd0, 8'd0, 8'd0}
   };

   // format per random phase, the last one runs with no idling at all
   localparam logic [1:0] PhaseFmt [NumPhases] = '{
      FormatDxt5, FormatDxt3, FormatSpare, FormatDxt1, FormatDxt5, FormatDxt3, FormatDxt1
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   dxtd_req_if req ();
   dxtd_rsp_if rsp ();
   dxtd_csr_if csr ();

   dxt_block_decoder u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   always #(ClkPeriod / 2) clock = ~clock;

   texel_type   expected_texels [$];
   logic [1:0]  cur_fmt;
   bit          idle_on;
   bit          hold_off_req;
   int unsigned mismatches;

   // decode one block under the given format and queue its sixteen texels
   function automatic void decode_block(input logic [1:0] fmt, input logic [63:0] cw,
                                        input logic [63:0] aw);
      logic [15:0] ends [2];
      int unsigned ep [2][3];
      int unsigned pal [4][4];
      int unsigned atab [8];
      int unsigned a0, a1, ci, av;
      bit          four;
      texel_type   t;
      ends[0] = cw[15:0];
      ends[1] = cw[31:16];
      // four-colour palette only when color0 is strictly above color1
      four = ends[0] > ends[1];
      for (int k = 0; k < 2; k++) begin
         ep[k][0] = 32'({ends[k][15:11], 3'b000});
         ep[k][1] = 32'({ends[k][10:5], 2'b00});
         ep[k][2] = 32'({ends[k][4:0], 3'b000});
      end
      for (int c = 0; c < 3; c++) begin
         pal[0][c] = ep[0][c];
         pal[1][c] = ep[1][c];
         if (four) begin
            pal[2][c] = (2 * ep[0][c] + ep[1][c]) / 3;
            pal[3][c] = (ep[0][c] + 2 * ep[1][c]) / 3;
         end else begin
            pal[2][c] = (ep[0][c] + ep[1][c]) / 2;
            pal[3][c] = 0;
         end
      end
      pal[0][3] = 255;
      pal[1][3] = 255;
      pal[2][3] = 255;
      pal[3][3] = four ? 255 : 0;

      // dxt5 alpha table: seven steps when a0 > a1, else five steps plus 0 and 255
      a0 = 32'(aw[7:0]);
      a1 = 32'(aw[15:8]);
      atab[0] = a0;
      atab[1] = a1;
      if (a0 > a1) begin
         for (int k = 2; k < 8; k++)
            atab[k] = ((8 - k) * a0 + (k - 1) * a1) / 7;
      end else begin
         for (int k = 2; k < 6; k++)
            atab[k] = ((6 - k) * a0 + (k - 1) * a1) / 5;
         atab[6] = 0;
         atab[7] = 255;
      end

      for (int i = 0; i < TexelCount; i++) begin
         ci = 32'(cw[32 + 2 * i +: 2]);
         av = pal[ci][3];
         if (fmt == FormatDxt3)
            av = aw[4 * i +: 4] * 17;
         else if (fmt == FormatDxt5)
            av = atab[aw[16 + 3 * i +: 3]];
         t.red   = chan_type'(pal[ci][0]);
         t.green = chan_type'(pal[ci][1]);
         t.blue  = chan_type'(pal[ci][2]);
         t.alpha = chan_type'(av);
         t.col   = 2'(i);
         t.row   = 2'(i >> 2);
         t.last  = (i == TexelCount - 1);
         expected_texels.push_back(t);
      end
   endfunction

   // offer one block word, with an occasional idle burst first
   task automatic offer_block(input logic [63:0] cw, input logic [63:0] aw);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req.valid      <= 1'b1;
      req.color_word <= cw;
      req.alpha_word <= aw;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   // format is only changed with nothing in flight
   task automatic write_format(input logic [1:0] fmt);
      req.valid <= 1'b0;
      while (expected_texels.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      csr.valid <= 1'b1;
      csr.data  <= fmt;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      csr.valid <= 1'b0;
      cur_fmt = fmt;
   endtask

   // stimulus: reset, directed table, then random phases
   initial begin
      logic [63:0] cw, aw;
      texel_type   t;
      req.valid      = 1'b0;
      req.color_word = '0;
      req.alpha_word = '0;
      csr.valid      = 1'b0;
      csr.data       = '0;
      cur_fmt        = FormatDxt1;
      idle_on        = 1'b1;
      hold_off_req   = 1'b0;
      mismatches     = 0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed blocks, grouped by format so the register changes only a few times
      for (int n = 0; n < NumDirected; n++) begin
         if (dir_rows[n].fmt != cur_fmt)
            write_format(dir_rows[n].fmt);
         offer_block(dir_rows[n].color_word, dir_rows[n].alpha_word);
         if (dir_rows[n].typed) begin
            for (int i = 0; i < TexelCount; i++) begin
               t.red   = dir_rows[n].red;
               t.green = dir_rows[n].green;
               t.blue  = dir_rows[n].blue;
               t.alpha = dir_rows[n].alpha;
               t.col   = 2'(i);
               t.row   = 2'(i >> 2);
               t.last  = (i == TexelCount - 1);
               expected_texels.push_back(t);
            end
         end else begin
            decode_block(cur_fmt, dir_rows[n].color_word, dir_rows[n].alpha_word);
         end
      end

      // random phases, each under its own format
      for (int p = 0; p < NumPhases; p++) begin
         write_format(PhaseFmt[p]);
         if (p == NumPhases - 1)
            idle_on = 1'b0;
         // long receiver hold-off while blocks keep coming, fills the pipeline
         if (p == 1)
            hold_off_req = 1'b1;
         for (int n = 0; n < PhaseBlocks; n++) begin
            cw = {$urandom, $urandom};
            aw = {$urandom, $urandom};
            // bias towards the palette and alpha-table boundaries
            case ($urandom_range(0, 9))
               0: cw[31:16] = cw[15:0];
               1: cw[15:0] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
               2: cw[31:16] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
               3: cw[31:16] = cw[15:0] - 16'd1;
               4: aw[15:8] = aw[7:0];
               5: aw[15:0] = $urandom_range(0, 1) ? 16'h00FF : 16'hFF00;
               6: aw[15:8] = aw[7:0] + 8'd1;
               default: ;
            endcase
            offer_block(cw, aw);
            decode_block(cur_fmt, cw, aw);
         end
      end
      req.valid <= 1'b0;

      // let the last texels drain, then wait quietly for anything stray
      while (expected_texels.size() != 0) @(posedge clock);
      repeat (DrainCycles * 4) @(posedge clock);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // texel receiver: random stall bursts, one long hold-off on request
   initial begin
      int stall_left;
      rsp.ready  = 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
         end else if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp.ready <= 1'b0;
            stall_left = LongHold - 1;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            rsp.ready <= 1'b0;
            stall_left = $urandom_range(1, 12) - 1;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // texel checker: every word taken on rsp against the oldest expected texel
   always @(posedge clock) begin : texel_check
      texel_type want, got;
      if (!reset && rsp.valid && rsp.ready) begin
         got = '{rsp.red, rsp.green, rsp.blue, rsp.alpha, rsp.texel_col, rsp.texel_row,
                 rsp.last};
         if (expected_texels.size() == 0) begin
            if (mismatches < ReportLimit)
               $display({"%0t: texel with none expected, expected none, ",
                         "actual r=%0d g=%0d b=%0d a=%0d"},
                        $time, got.red, got.green, got.blue, got.alpha);
            mismatches++;
         end else begin
            want = expected_texels.pop_front();
            if (got !== want) begin
               if (mismatches < ReportLimit)
                  $display({"%0t: texel mismatch, expected r=%0d g=%0d b=%0d a=%0d ",
                            "col=%0d row=%0d last=%0d, actual r=%0d g=%0d b=%0d a=%0d ",
                            "col=%0d row=%0d last=%0d"},
                           $time, want.red, want.green, want.blue, want.alpha,
                           want.col, want.row, want.last, got.red, got.green, got.blue,
                           got.alpha, got.col, got.row, got.last);
               mismatches++;
            end
         end
      end
   end

   // hard stop well beyond the slowest correct run
   initial begin
      #(TimeoutCycles * ClkPeriod);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
